// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ----- rtl/gsa_pkg.sv -----
package gsa_pkg;

   localparam int NODE_DEPTH = 4096;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_W = 12;
   localparam int SYM_W = 5;
   localparam int CNT_W = 32;
   localparam int K_W = 5;
   localparam int TR_DEPTH = NODE_DEPTH * ALPHABET_SIZE;
   localparam int TR_AW = $clog2(TR_DEPTH);

   localparam logic [K_W-1:0] K_LAST = K_W'(ALPHABET_SIZE - 1);
   localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);
   localparam logic [NODE_W-1:0] NODE_LIMIT1 = NODE_W'(NODE_DEPTH - 2);
   localparam logic [NODE_W-1:0] NODE_LIMIT2 = NODE_W'(NODE_DEPTH - 3);

   typedef logic [NODE_W-1:0] node_type;

   // Datapath micro-operations issued by the controller states (ST_RLX and ST_CLX share OP_RD_LX)
   typedef enum logic [4:0] {
      OP_NONE, OP_CLR_ROOT, OP_LATCH, OP_RD_X, OP_GOT_X, OP_RD_LX, OP_GOT_LX,
      OP_ALLOC_Y, OP_CP_RD, OP_CP_WR, OP_RED_RD, OP_RED_GOT, OP_LX_RD,
      OP_LX_WR, OP_LX_SET, OP_CW_RD, OP_CW_GOT, OP_CL_GOT, OP_ALLOC_Z,
      OP_CLR_Z, OP_WW_RD, OP_WW_GOT, OP_FIN, OP_RESP
   } dp_op_type;

   typedef enum logic [2:0] {
      RS_ZERO, RS_X, RS_Y, RS_Z, RS_FULL
   } resp_sel_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_RX, ST_GX, ST_RLX, ST_GLX, ST_AY, ST_CPR, ST_CPW,
      ST_RR, ST_RG, ST_LXR, ST_LXW, ST_LXS, ST_CW, ST_CWG, ST_CLX, ST_CLG,
      ST_CHK, ST_CZ, ST_WR, ST_WG, ST_FIN, ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      resp_sel_type rsel;
   } dp_cmd_type;

   typedef struct packed {
      logic sym_bad;
      logic x_nz;
      logic match;
      logic room1;
      logic room_need;
      logic k_last;
      logic red_hit;
      logic lnk_nz;
      logic lnk_eq_q;
      logic q_zero;
      logic two;
      logic direct;
   } dp_status_type;

   // First table address of a node's row
   function automatic logic [TR_AW-1:0] row_base(input node_type r);
      row_base = TR_AW'(r) * TR_AW'(ALPHABET_SIZE);
   endfunction

endpackage

// ----- rtl/generalized_suffix_automaton_extend.sv -----
// Work per item: a symbol outside the alphabet goes straight to the result; a
// direct hit or a refused split ends after the transition and length reads; a new
// state walks the suffix links to the node given the transition (further when an
// existing one ends the walk); a clone adds a 26-entry row copy and link redirects.
// Throughput: one item at a time; the next item is taken once busy falls.
// Reset: synchronous; busy stays high while the root row is cleared; no result stall.
module generalized_suffix_automaton_extend import gsa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [NODE_W-1:0] req_prev_state,
   output logic              rsp_strobe,
   output logic [NODE_W-1:0] rsp_new_state,
   output logic [CNT_W-1:0]  rsp_distinct_count,
   output logic              rsp_full_res
);

   dp_cmd_type cmd;
   dp_status_type sts;

   gsa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .cmd(cmd));

   gsa_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_symbol(req_symbol), .req_prev_state(req_prev_state),
      .rsp_strobe(rsp_strobe), .rsp_new_state(rsp_new_state),
      .rsp_distinct_count(rsp_distinct_count), .rsp_full_res(rsp_full_res));

endmodule

// ----- rtl/gsa_ram.sv -----
module gsa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/gsa_ctrl.sv -----
module gsa_ctrl import gsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   resp_sel_type rsel_ff, rsel_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rsel_ff <= RS_ZERO;
      end else begin
         state_ff <= state_in;
         rsel_ff <= rsel_in;
      end
   end

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      rsel_in = rsel_ff;
      cmd.op = OP_NONE;
      cmd.rsel = rsel_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.op = OP_CLR_ROOT;
            if (sts.k_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.op = OP_LATCH;
               if (sts.sym_bad) begin
                  rsel_in = RS_ZERO;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_RX;
               end
            end
         end
         ST_RX: begin
            cmd.op = OP_RD_X;
            state_in = ST_GX;
         end
         ST_GX: begin
            cmd.op = OP_GOT_X;
            state_in = sts.x_nz ? ST_RLX : ST_CW;
         end
         ST_RLX: begin
            cmd.op = OP_RD_LX;
            state_in = ST_GLX;
         end
         ST_GLX: begin
            cmd.op = OP_GOT_LX;
            if (sts.match) begin
               rsel_in = RS_X;
               state_in = ST_RESP;
            end else if (!sts.room1) begin
               rsel_in = RS_FULL;
               state_in = ST_RESP;
            end else begin
               state_in = ST_AY;
            end
         end
         // split: allocate clone, copy row, redirect, relink
         ST_AY: begin
            cmd.op = OP_ALLOC_Y;
            state_in = ST_CPR;
         end
         ST_CPR: begin
            cmd.op = OP_CP_RD;
            state_in = ST_CPW;
         end
         ST_CPW: begin
            cmd.op = OP_CP_WR;
            state_in = sts.k_last ? ST_RR : ST_CPR;
         end
         ST_RR: begin
            cmd.op = OP_RED_RD;
            state_in = ST_RG;
         end
         ST_RG: begin
            cmd.op = OP_RED_GOT;
            state_in = (sts.red_hit && sts.lnk_nz) ? ST_RR : ST_LXR;
         end
         ST_LXR: begin
            cmd.op = OP_LX_RD;
            state_in = ST_LXW;
         end
         ST_LXW: begin
            cmd.op = OP_LX_WR;
            state_in = ST_LXS;
         end
         ST_LXS: begin
            cmd.op = OP_LX_SET;
            if (sts.direct) begin
               rsel_in = RS_Y;
               state_in = ST_RESP;
            end else begin
               state_in = ST_FIN;
            end
         end
         // sizing walk over suffix links
         ST_CW: begin
            cmd.op = OP_CW_RD;
            state_in = ST_CWG;
         end
         ST_CWG: begin
            cmd.op = OP_CW_GOT;
            if (sts.x_nz) state_in = ST_CLX;
            else if (sts.lnk_nz) state_in = ST_CW;
            else state_in = ST_CHK;
         end
         ST_CLX: begin
            cmd.op = OP_RD_LX;
            state_in = ST_CLG;
         end
         ST_CLG: begin
            cmd.op = OP_CL_GOT;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.op = OP_ALLOC_Z;
            if (sts.room_need) begin
               state_in = ST_CZ;
            end else begin
               rsel_in = RS_FULL;
               state_in = ST_RESP;
            end
         end
         ST_CZ: begin
            cmd.op = OP_CLR_Z;
            state_in = sts.k_last ? ST_WR : ST_CZ;
         end
         // writing walk up to the stop node
         ST_WR: begin
            cmd.op = OP_WW_RD;
            state_in = ST_WG;
         end
         ST_WG: begin
            cmd.op = OP_WW_GOT;
            if (!sts.lnk_eq_q) state_in = ST_WR;
            else if (sts.q_zero || !sts.two) state_in = ST_FIN;
            else state_in = ST_AY;
         end
         ST_FIN: begin
            cmd.op = OP_FIN;
            rsel_in = RS_Z;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            cmd.op = OP_RESP;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/gsa_datapath.sv -----
module gsa_datapath import gsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      sts,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic [NODE_W-1:0]  req_prev_state,
   output logic               rsp_strobe,
   output logic [NODE_W-1:0]  rsp_new_state,
   output logic [CNT_W-1:0]   rsp_distinct_count,
   output logic               rsp_full_res
);

   // Control registers
   node_type count_ff, count_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [K_W-1:0] k_ff, k_in;
   logic strobe_ff, strobe_in;
   // Working registers
   logic [SYM_W-1:0] c_ff, c_in;
   node_type last_ff, last_in, p_ff, p_in, q_ff, q_in;
   node_type x_ff, x_in, y_ff, y_in, z_ff, z_in;
   node_type lenlast_ff, lenlast_in, lenp_ff, lenp_in, lenx_ff, lenx_in;
   node_type newlen_ff, newlen_in;
   logic two_ff, two_in, direct_ff, direct_in;
   node_type nstate_ff, nstate_in;
   logic [CNT_W-1:0] dcount_ff, dcount_in;
   logic full_ff, full_in;

   // Memory ports
   logic tr_we, ln_we, le_we;
   logic [TR_AW-1:0] tr_waddr, tr_raddr;
   node_type tr_wdata, tr_rdata;
   node_type ln_waddr, ln_raddr, ln_wdata, ln_rdata;
   node_type le_waddr, le_raddr, le_wdata, le_rdata;

   logic [TR_AW-1:0] a_pc, a_lc, a_xk, a_yk, a_zk, a_rk;
   node_type lenz, lenlink, linkz;
   logic [CNT_W:0] sum;

   gsa_ram #(.WIDTH(NODE_W), .DEPTH(TR_DEPTH)) u_tr (
      .clock(clock), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
      .raddr(tr_raddr), .rdata(tr_rdata));
   gsa_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_link (
      .clock(clock), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
      .raddr(ln_raddr), .rdata(ln_rdata));
   gsa_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_len (
      .clock(clock), .we(le_we), .waddr(le_waddr), .wdata(le_wdata),
      .raddr(le_raddr), .rdata(le_rdata));

   // Table addresses
   assign a_pc = row_base(p_ff) + TR_AW'(c_ff);
   assign a_lc = row_base(last_ff) + TR_AW'(c_ff);
   assign a_xk = row_base(x_ff) + TR_AW'(k_ff);
   assign a_yk = row_base(y_ff) + TR_AW'(k_ff);
   assign a_zk = row_base(z_ff) + TR_AW'(k_ff);
   assign a_rk = row_base(ROOT) + TR_AW'(k_ff);

   // New state's suffix link and the length it stands on
   assign lenz = lenlast_ff + NODE_W'(1);
   always_comb begin
      if (q_ff == '0) begin
         linkz = ROOT;
         lenlink = '0;
      end else if (!two_ff) begin
         linkz = x_ff;
         lenlink = lenx_ff;
      end else begin
         linkz = y_ff;
         lenlink = newlen_ff;
      end
   end
   assign sum = {1'b0, total_ff} + (CNT_W + 1)'(lenz - lenlink);

   // Status to the controller
   always_comb begin
      sts.sym_bad = (req_symbol >= SYM_W'(ALPHABET_SIZE));
      sts.x_nz = (tr_rdata != '0);
      sts.match = (lenlast_ff + NODE_W'(1) == le_rdata);
      sts.room1 = (count_ff <= NODE_LIMIT1);
      sts.room_need = two_ff ? (count_ff <= NODE_LIMIT2) : (count_ff <= NODE_LIMIT1);
      sts.k_last = (k_ff == K_LAST);
      sts.red_hit = (tr_rdata == x_ff);
      sts.lnk_nz = (ln_rdata != '0);
      sts.lnk_eq_q = (ln_rdata == q_ff);
      sts.q_zero = (q_ff == '0);
      sts.two = two_ff;
      sts.direct = direct_ff;
   end

   // Micro-operation decode
   always_comb begin
      count_in = count_ff;   total_in = total_ff;   k_in = k_ff;
      strobe_in = 1'b0;      c_in = c_ff;           last_in = last_ff;
      p_in = p_ff;           q_in = q_ff;           x_in = x_ff;
      y_in = y_ff;           z_in = z_ff;           lenlast_in = lenlast_ff;
      lenp_in = lenp_ff;     lenx_in = lenx_ff;     newlen_in = newlen_ff;
      two_in = two_ff;       direct_in = direct_ff; nstate_in = nstate_ff;
      dcount_in = dcount_ff; full_in = full_ff;
      tr_we = 1'b0; tr_waddr = a_pc; tr_wdata = '0; tr_raddr = a_pc;
      ln_we = 1'b0; ln_waddr = p_ff; ln_wdata = '0; ln_raddr = p_ff;
      le_we = 1'b0; le_waddr = p_ff; le_wdata = '0; le_raddr = p_ff;
      unique case (cmd.op)
         OP_NONE: ;
         OP_CLR_ROOT: begin
            tr_we = 1'b1;
            tr_waddr = a_rk;
            k_in = sts.k_last ? '0 : k_ff + K_W'(1);
            if (sts.k_last) begin
               ln_we = 1'b1;
               ln_waddr = ROOT;
               le_we = 1'b1;
               le_waddr = ROOT;
            end
         end
         OP_LATCH: begin
            c_in = req_symbol;
            last_in = (req_prev_state == '0 || req_prev_state > count_ff) ?
                      ROOT : req_prev_state;
         end
         OP_RD_X: begin
            tr_raddr = a_lc;
            le_raddr = last_ff;
         end
         OP_GOT_X: begin
            x_in = tr_rdata;
            lenlast_in = le_rdata;
            p_in = last_ff;
            direct_in = 1'b0;
         end
         OP_RD_LX: le_raddr = x_ff;
         OP_GOT_LX: begin
            lenx_in = le_rdata;
            newlen_in = lenlast_ff + NODE_W'(1);
            direct_in = 1'b1;
         end
         OP_ALLOC_Y: begin
            y_in = count_ff + NODE_W'(1);
            count_in = count_ff + NODE_W'(1);
            le_we = 1'b1;
            le_waddr = count_ff + NODE_W'(1);
            le_wdata = newlen_ff;
         end
         OP_CP_RD: tr_raddr = a_xk;
         OP_CP_WR: begin
            tr_we = 1'b1;
            tr_waddr = a_yk;
            tr_wdata = tr_rdata;
            k_in = sts.k_last ? '0 : k_ff + K_W'(1);
         end
         OP_RED_RD: begin
            tr_raddr = a_pc;
            ln_raddr = p_ff;
         end
         OP_RED_GOT: begin
            if (sts.red_hit) begin
               tr_we = 1'b1;
               tr_waddr = a_pc;
               tr_wdata = y_ff;
               p_in = ln_rdata;
            end
         end
         OP_LX_RD: ln_raddr = x_ff;
         OP_LX_WR: begin
            ln_we = 1'b1;
            ln_waddr = y_ff;
            ln_wdata = ln_rdata;
         end
         OP_LX_SET: begin
            ln_we = 1'b1;
            ln_waddr = x_ff;
            ln_wdata = y_ff;
         end
         OP_CW_RD: begin
            tr_raddr = a_pc;
            ln_raddr = p_ff;
            le_raddr = p_ff;
         end
         OP_CW_GOT: begin
            if (tr_rdata == '0) begin
               p_in = ln_rdata;
               if (ln_rdata == '0) begin
                  q_in = '0;
                  two_in = 1'b0;
               end
            end else begin
               x_in = tr_rdata;
               lenp_in = le_rdata;
               q_in = p_ff;
            end
         end
         OP_CL_GOT: begin
            lenx_in = le_rdata;
            newlen_in = lenp_ff + NODE_W'(1);
            two_in = (lenp_ff + NODE_W'(1) != le_rdata);
         end
         OP_ALLOC_Z: begin
            if (sts.room_need) begin
               z_in = count_ff + NODE_W'(1);
               count_in = count_ff + NODE_W'(1);
               le_we = 1'b1;
               le_waddr = count_ff + NODE_W'(1);
               le_wdata = lenz;
               p_in = last_ff;
               k_in = '0;
            end
         end
         OP_CLR_Z: begin
            tr_we = 1'b1;
            tr_waddr = a_zk;
            k_in = sts.k_last ? '0 : k_ff + K_W'(1);
         end
         OP_WW_RD: begin
            tr_we = 1'b1;
            tr_waddr = a_pc;
            tr_wdata = z_ff;
            ln_raddr = p_ff;
         end
         OP_WW_GOT: p_in = ln_rdata;
         OP_FIN: begin
            ln_we = 1'b1;
            ln_waddr = z_ff;
            ln_wdata = linkz;
            total_in = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
         end
         OP_RESP: begin
            strobe_in = 1'b1;
            dcount_in = total_ff;
            full_in = (cmd.rsel == RS_FULL);
            case (cmd.rsel)
               RS_X: nstate_in = x_ff;
               RS_Y: nstate_in = y_ff;
               RS_Z: nstate_in = z_ff;
               default: nstate_in = '0;
            endcase
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ROOT;
         total_ff <= '0;
         k_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         k_ff <= k_in;
         strobe_ff <= strobe_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      c_ff <= c_in;           last_ff <= last_in;     p_ff <= p_in;
      q_ff <= q_in;           x_ff <= x_in;           y_ff <= y_in;
      z_ff <= z_in;           lenlast_ff <= lenlast_in;
      lenp_ff <= lenp_in;     lenx_ff <= lenx_in;     newlen_ff <= newlen_in;
      two_ff <= two_in;       direct_ff <= direct_in; nstate_ff <= nstate_in;
      dcount_ff <= dcount_in; full_ff <= full_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_new_state = nstate_ff;
   assign rsp_distinct_count = dcount_ff;
   assign rsp_full_res = full_ff;

endmodule

// ----- rtl/gsa_checker.sv -----
`include "assert_macros.svh"

module gsa_checker import gsa_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [NODE_W-1:0] rsp_new_state,
   input logic              rsp_full_res
);

   // An accepted item keeps the block busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // One strobe per item, never two in a row
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   // A result is shown only once the block is free again
   `ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // A refused item carries no state
   `ASSERT_IMP(a_full_zero, clock, reset, rsp_strobe && rsp_full_res, rsp_new_state == '0)

endmodule

bind generalized_suffix_automaton_extend gsa_checker u_gsa_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gsa_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int TAIL_CYCLES = 200;

   typedef struct {
      logic [SYM_W-1:0] sym;
      node_type         prev;
      bit               chain;   // extend the state returned for the previous item
      bit               drain;   // hold off until every result is back
   } ext_item_t;

   typedef struct {
      node_type         state;
      logic [CNT_W-1:0] count;
      logic             full;
   } ext_result_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [SYM_W-1:0]  req_symbol = '0;
   logic [NODE_W-1:0] req_prev_state = '0;
   logic              rsp_strobe;
   logic [NODE_W-1:0] rsp_new_state;
   logic [CNT_W-1:0]  rsp_distinct_count;
   logic              rsp_full_res;

   generalized_suffix_automaton_extend dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_symbol         (req_symbol),
      .req_prev_state     (req_prev_state),
      .rsp_strobe         (rsp_strobe),
      .rsp_new_state      (rsp_new_state),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_full_res       (rsp_full_res)
   );

   always #1 clock = ~clock;

   // Shadow automaton
   bit [NODE_W-1:0] shadow_trans [NODE_DEPTH][ALPHABET_SIZE];
   int unsigned     shadow_link  [NODE_DEPTH];
   int unsigned     shadow_len   [NODE_DEPTH];
   int unsigned     shadow_nodes = 1;
   bit [CNT_W-1:0]  shadow_total = '0;

   ext_item_t   pending_items[$];
   ext_result_t expected_results[$];
   int          errors = 0;
   int          idle_cycles = 0;

   // Split state x into a fresh clone of length len, redirecting links from p
   function automatic int unsigned clone_state(int unsigned p, int unsigned c,
                                               int unsigned x, int unsigned len);
      int unsigned y;
      int unsigned guard;
      shadow_nodes++;
      y = shadow_nodes;
      guard = 0;
      shadow_len[y] = len;
      for (int k = 0; k < ALPHABET_SIZE; k++)
         shadow_trans[y][k] = shadow_trans[x][k];
      while (p != 0 && 32'(shadow_trans[p][c]) == x && guard < NODE_DEPTH) begin
         shadow_trans[p][c] = NODE_W'(y);
         p = shadow_link[p];
         guard++;
      end
      shadow_link[y] = shadow_link[x];
      shadow_link[x] = y;
      return y;
   endfunction

   // Append one symbol to the string held by prev; returns the expected result
   function automatic ext_result_t extend_automaton(logic [SYM_W-1:0] sym, node_type prev);
      ext_result_t r;
      int unsigned c, last, x, p, need, z, guard, add;
      r.state = '0;
      r.full = 1'b0;
      c = 32'(sym);
      last = 32'(prev);
      if (c < ALPHABET_SIZE) begin
         if (last == 0 || last > shadow_nodes) last = 1;
         x = 32'(shadow_trans[last][c]);
         if (x != 0) begin
            // existing transition: direct hit or split
            if (shadow_len[last] + 1 == shadow_len[x])
               r.state = NODE_W'(x);
            else if (shadow_nodes + 1 > NODE_DEPTH - 1)
               r.full = 1'b1;
            else
               r.state = NODE_W'(clone_state(last, c, x, shadow_len[last] + 1));
         end else begin
            // size the need before touching anything
            p = last;
            guard = 0;
            while (p != 0 && shadow_trans[p][c] == 0 && guard < NODE_DEPTH) begin
               p = shadow_link[p];
               guard++;
            end
            need = 1;
            if (p != 0 && shadow_len[p] + 1 != shadow_len[shadow_trans[p][c]]) need = 2;
            if (shadow_nodes + need > NODE_DEPTH - 1) begin
               r.full = 1'b1;
            end else begin
               shadow_nodes++;
               z = shadow_nodes;
               shadow_len[z] = shadow_len[last] + 1;
               p = last;
               guard = 0;
               while (p != 0 && shadow_trans[p][c] == 0 && guard < NODE_DEPTH) begin
                  shadow_trans[p][c] = NODE_W'(z);
                  p = shadow_link[p];
                  guard++;
               end
               if (p == 0) begin
                  shadow_link[z] = 1;
               end else begin
                  x = 32'(shadow_trans[p][c]);
                  if (shadow_len[p] + 1 == shadow_len[x])
                     shadow_link[z] = x;
                  else
                     shadow_link[z] = clone_state(p, c, x, shadow_len[p] + 1);
               end
               add = shadow_len[z] - shadow_len[shadow_link[z]];
               if (add > 32'hFFFF_FFFF - shadow_total) shadow_total = 32'hFFFF_FFFF;
               else shadow_total += add;
               r.state = NODE_W'(z);
            end
         end
      end
      r.count = shadow_total;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, field, got, want);
      errors++;
   endtask

   function automatic void add_item(int sym, int prev, int chain, int drain);
      ext_item_t it;
      it.sym = SYM_W'(sym);
      it.prev = NODE_W'(prev);
      it.chain = (chain != 0);
      it.drain = (drain != 0);
      pending_items.push_back(it);
   endfunction

   // Driver: bursts of items with random gaps between them
   node_type last_state = ROOT;
   int       burst_left = 0;
   int       gap_left = 0;

   always @(posedge clock) begin
      ext_item_t   it;
      ext_result_t res;
      bit          taken;
      bit          hold;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            res = extend_automaton(req_symbol, req_prev_state);
            expected_results.push_back(res);
            last_state = res.state;
         end
         hold = start && !taken;
         if (hold) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      !(pending_items[0].drain && expected_results.size() != 0)) begin
            it = pending_items.pop_front();
            req_symbol <= it.sym;
            req_prev_state <= it.chain ? last_state : it.prev;
            start <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is checked against the oldest expectation
   always @(posedge clock) begin
      ext_result_t want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("MISMATCH %0t: result with nothing outstanding", $realtime);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_new_state !== want.state)
               report_mismatch("new_state", 64'(rsp_new_state), 64'(want.state));
            if (rsp_distinct_count !== want.count)
               report_mismatch("distinct_count", 64'(rsp_distinct_count), 64'(want.count));
            if (rsp_full_res !== want.full)
               report_mismatch("full_res", 64'(rsp_full_res), 64'(want.full));
         end
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int len;
      // directed: extremes, ignored symbols, unallocated predecessors
      add_item(0, 1, 0, 0);
      add_item(25, 1, 0, 0);
      add_item(26, 1, 0, 0);
      add_item(31, 4095, 0, 0);
      add_item(0, 0, 0, 0);
      add_item(25, 4095, 0, 0);
      // "ab", then "b" from root forces a split
      add_item(0, 1, 0, 0);
      add_item(1, 0, 1, 0);
      add_item(1, 1, 0, 0);
      // existing transition with matching length returns target directly
      add_item(0, 1, 0, 1);
      add_item(1, 0, 1, 0);
      add_item(2, 0, 1, 0);
      add_item(1, 1, 0, 0);
      add_item(2, 0, 1, 0);
      add_item(31, 0, 1, 1);

      // random: mostly strings over a few letters, some noise
      for (int n = 0; n < 850; ) begin
         if ($urandom_range(0, 9) < 8) begin
            len = $urandom_range(1, 12);
            add_item($urandom_range(0, 3), 1, 0, int'($urandom_range(0, 60) == 0));
            for (int k = 1; k < len; k++)
               add_item($urandom_range(0, 3), 0, 1, 0);
            n += len;
         end else begin
            add_item($urandom_range(0, 31), $urandom_range(0, 4095), 0, 0);
            n++;
         end
      end
      add_item(24, $urandom_range(0, 4095), 0, 0);
      add_item(31, 1, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_items.size() != 0 || start || expected_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
